>>> src/scanline_rle_encoder_with_clip_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file of the scanline RLE encoder
// ----------------------------------------------------------------------------
`ifndef SCANLINE_RLE_ENCODER_WITH_CLIP_DEFINES_SVH
`define SCANLINE_RLE_ENCODER_WITH_CLIP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SLRLE_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted
`define SLRLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> src/slrle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slrle_pkg
// Types and constants of the scanline RLE encoder with clip information.
// ----------------------------------------------------------------------------
package slrle_pkg;

    // Record kinds
    localparam logic [1:0] KIND_RUN   = 2'd0;
    localparam logic [1:0] KIND_CLIP  = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_LINE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_EXTRA_BYTES  = 2'd2;

    // Register reset values
    localparam logic [12:0] LINE_WIDTH_RST   = 13'd64;
    localparam logic [12:0] IMAGE_HEIGHT_RST = 13'd64;
    localparam logic [15:0] EXTRA_BYTES_RST  = 16'd0;

    // Header size of the reset configuration
    localparam logic [31:0] WRITE_OFFSET_RST =
        {18'd0, IMAGE_HEIGHT_RST, 1'b0} + {16'd0, EXTRA_BYTES_RST};

    // Encoding constants
    localparam logic [7:0]  RUN_CAP     = 8'd255;
    localparam logic [7:0]  OPAQUE_MASK = 8'h1F;
    localparam logic [12:0] MAX_HEIGHT  = 13'd4096;

    // Records produced by one pixel, and the record queue
    localparam int MAX_PUSH   = 4;
    localparam int PUSH_W     = 3;
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = 3;
    localparam int CNT_W      = 4;

    typedef struct packed {
        logic [12:0] line_width;
        logic [12:0] image_height;
        logic [15:0] extra_bytes;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [11:0] line;
        logic [15:0] offs;
        logic [31:0] total;
        logic        img_end;
        logic        last;
    } rec_t;

endpackage

>>> src/slrle_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slrle_core
// Run, clip and line state; builds the records caused by one pixel.
// ----------------------------------------------------------------------------
module slrle_core #(
    parameter int MAX_LINE = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 acc,
    input  logic [7:0]           pixel,
    input  slrle_pkg::cfg_t      cfg,
    output logic [2:0]           push_n,
    output slrle_pkg::rec_t      recs [slrle_pkg::MAX_PUSH]
);
    import slrle_pkg::*;

    localparam int WW = (MAX_LINE > 1) ? $clog2(MAX_LINE + 1) : 1;
    localparam int CW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;

    logic [7:0]    run_pixel_reg, run_pixel_next;
    logic [7:0]    run_count_reg, run_count_next;
    logic [CW-1:0] column_reg, column_next;
    logic [11:0]   row_reg, row_next;
    logic [31:0]   write_offset_reg, write_offset_next;
    logic [31:0]   row_start_reg, row_start_next;
    logic [WW-1:0] solid_count_reg, solid_count_next;
    logic [WW-1:0] best_length_reg, best_length_next;
    logic [CW-1:0] best_start_reg, best_start_next;

    logic [WW-1:0] eff_w;
    logic [12:0]   eff_h;

    // Clamp width and height to their legal ranges
    always_comb
    begin
        if (cfg.line_width == 13'd0)
            eff_w = WW'(1);
        else if (32'(cfg.line_width) > 32'(MAX_LINE))
            eff_w = WW'(MAX_LINE);
        else
            eff_w = WW'(cfg.line_width);

        if (cfg.image_height == 13'd0)
            eff_h = 13'd1;
        else if (cfg.image_height > MAX_HEIGHT)
            eff_h = MAX_HEIGHT;
        else
            eff_h = cfg.image_height;
    end

    // Per-pixel record generation and next state
    always_comb
    begin
        logic [31:0]   wo;
        logic [31:0]   rs;
        logic [7:0]    rp;
        logic [7:0]    rc;
        logic [WW-1:0] sc;
        logic [WW-1:0] bl;
        logic [CW-1:0] bs;
        logic [WW-1:0] col_inc;
        logic [WW-1:0] tail_start;
        logic [31:0]   clip_end;
        logic [31:0]   tab;
        logic [15:0]   so;
        logic          endimg;
        logic [2:0]    n;

        for (int i = 0; i < MAX_PUSH; i++)
            recs[i] = '0;
        n  = 3'd0;
        wo = write_offset_reg;
        rs = row_start_reg;
        rp = run_pixel_reg;
        rc = run_count_reg;
        sc = solid_count_reg;
        bl = best_length_reg;
        bs = best_start_reg;
        col_inc    = WW'(column_reg) + WW'(1);
        tail_start = '0;
        clip_end   = '0;
        tab    = {19'd0, row_reg, 1'b0};
        so     = '0;
        endimg = ({1'b0, row_reg} + 13'd1) >= eff_h;
        row_next    = row_reg;
        column_next = column_reg;

        // Run tracking; a new line reloads the header at image start
        if (column_reg == '0) begin
            if (row_reg == 12'd0)
                wo = {18'd0, eff_h, 1'b0} + {16'd0, cfg.extra_bytes};
            rs = wo;
            wo = wo + 32'd2;
            rp = pixel;
            rc = 8'd1;
            sc = '0;
            bl = '0;
            bs = '0;
        end else if (pixel == run_pixel_reg && run_count_reg < RUN_CAP) begin
            rc = run_count_reg + 8'd1;
        end else begin
            recs[n[1:0]].kind = KIND_RUN;
            recs[n[1:0]].addr = wo;
            recs[n[1:0]].b0   = run_count_reg;
            recs[n[1:0]].b1   = run_pixel_reg;
            recs[n[1:0]].line = row_reg;
            n  = n + 3'd1;
            wo = wo + 32'd2;
            rp = pixel;
            rc = 8'd1;
        end

        // Longest opaque stretch
        if ((pixel & OPAQUE_MASK) != 8'd0) begin
            sc = sc + WW'(1);
        end else begin
            if (sc > bl) begin
                bl = sc;
                bs = column_reg - sc[CW-1:0];
            end
            sc = '0;
        end

        // End of line
        if (col_inc >= eff_w) begin
            if (sc > bl) begin
                bl = sc;
                tail_start = col_inc - sc;
                bs = tail_start[CW-1:0];
            end
            if ((rp & OPAQUE_MASK) == 8'd0 && 32'(rc) == 32'(eff_w)) begin
                // Fully transparent line: only a zero start offset
                wo = rs;
                recs[n[1:0]].kind    = KIND_START;
                recs[n[1:0]].addr    = tab;
                recs[n[1:0]].line    = row_reg;
                recs[n[1:0]].img_end = endimg;
                n = n + 3'd1;
            end else begin
                so = rs[15:0];
                clip_end = 32'(bs) + 32'(bl);
                recs[n[1:0]].kind = KIND_RUN;
                recs[n[1:0]].addr = wo;
                recs[n[1:0]].b0   = rc;
                recs[n[1:0]].b1   = rp;
                recs[n[1:0]].line = row_reg;
                n  = n + 3'd1;
                wo = wo + 32'd2;
                recs[n[1:0]].kind = KIND_CLIP;
                recs[n[1:0]].addr = rs;
                recs[n[1:0]].b0   = 8'(32'(bs));
                recs[n[1:0]].b1   = clip_end[7:0];
                recs[n[1:0]].line = row_reg;
                n = n + 3'd1;
                recs[n[1:0]].kind    = KIND_START;
                recs[n[1:0]].addr    = tab;
                recs[n[1:0]].b0      = so[7:0];
                recs[n[1:0]].b1      = so[15:8];
                recs[n[1:0]].line    = row_reg;
                recs[n[1:0]].offs    = so;
                recs[n[1:0]].img_end = endimg;
                n = n + 3'd1;
            end
            column_next = '0;
            row_next    = endimg ? 12'd0 : row_reg + 12'd1;
        end else begin
            column_next = column_reg + CW'(1);
        end

        // Running length and final-record flag
        for (int i = 0; i < MAX_PUSH; i++) begin
            recs[i].total = wo;
            recs[i].last  = (3'(i) == n - 3'd1);
        end

        push_n            = acc ? n : 3'd0;
        run_pixel_next    = rp;
        run_count_next    = rc;
        write_offset_next = wo;
        row_start_next    = rs;
        solid_count_next  = sc;
        best_length_next  = bl;
        best_start_next   = bs;
    end

    // State registers, updated on each accepted pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            run_pixel_reg    <= '0;
            run_count_reg    <= '0;
            column_reg       <= '0;
            row_reg          <= '0;
            write_offset_reg <= WRITE_OFFSET_RST;
            row_start_reg    <= '0;
            solid_count_reg  <= '0;
            best_length_reg  <= '0;
            best_start_reg   <= '0;
        end else if (acc) begin
            run_pixel_reg    <= run_pixel_next;
            run_count_reg    <= run_count_next;
            column_reg       <= column_next;
            row_reg          <= row_next;
            write_offset_reg <= write_offset_next;
            row_start_reg    <= row_start_next;
            solid_count_reg  <= solid_count_next;
            best_length_reg  <= best_length_next;
            best_start_reg   <= best_start_next;
        end
    end

endmodule

>>> src/slrle_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slrle_fifo
// Record queue: takes up to four records a cycle, delivers one a cycle when popped.
// ----------------------------------------------------------------------------
module slrle_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [2:0]           push_n,
    input  slrle_pkg::rec_t      recs [slrle_pkg::MAX_PUSH],
    input  logic                 pop,
    output logic                 not_empty,
    output logic                 full,
    output slrle_pkg::rec_t      head
);
    import slrle_pkg::*;

    rec_t             mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign not_empty = (count_reg != '0);
    // Room must remain for a full set of records from one pixel
    assign full = (count_reg > CNT_W'(FIFO_DEPTH - MAX_PUSH));
    assign head = mem[rd_ptr_reg];

    // Pointer and fill arithmetic
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push_n) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Record storage
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_PUSH; i++) begin
            if (3'(i) < push_n)
                mem[wr_ptr_reg + PTR_W'(i)] <= recs[i];
        end
    end

endmodule

>>> src/scanline_rle_encoder_with_clip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scanline_rle_encoder_with_clip
// Encodes raster pixels into (length, pixel) run pairs with per-line clip info.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on in_valid/in_stall/pixel in raster order. Each request is
//   taken at a clock edge with in_valid high and in_stall low. Records leave
//   on out_valid/out_stall with one field port each; 'last' marks the final
//   record caused by one pixel. A pixel causes zero to four records, which
//   enter the record queue as the pixel is accepted. Throughput: one pixel per
//   cycle while pixels cause at most one record; the output port delivers one
//   record per cycle while out_stall is low, from an eight-entry record queue,
//   which also sets the pace at line ends (up to four records). in_stall rises
//   while fewer than four queue entries are free, so a stalled receiver
//   back-pressures the input after a few records. Registers (line_width,
//   image_height, extra_bytes) are written on cfg_we with cfg_index/cfg_data
//   while idle; the user must ensure this, as the block does not. The header
//   size is loaded at the first pixel of an image; width and height bound the
//   current line at once. Reset empties the queue, loads the register reset
//   values and starts a new image at line 0, column 0.
// ----------------------------------------------------------------------------
module scanline_rle_encoder_with_clip #(
    parameter int MAX_LINE = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // Pixel channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  pixel,
    // Record channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  record_kind,
    output logic [31:0] byte_address,
    output logic [7:0]  first_byte,
    output logic [7:0]  second_byte,
    output logic [11:0] line_number,
    output logic [15:0] line_offset,
    output logic [31:0] total_bytes,
    output logic        image_end,
    output logic        last
);
    import slrle_pkg::*;

    cfg_t       cfg_reg;
    logic       in_acc;
    logic       out_acc;
    logic       q_full;
    logic [2:0] push_n;
    rec_t       recs [MAX_PUSH];
    rec_t       head;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.line_width   <= LINE_WIDTH_RST;
            cfg_reg.image_height <= IMAGE_HEIGHT_RST;
            cfg_reg.extra_bytes  <= EXTRA_BYTES_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_LINE_WIDTH:   cfg_reg.line_width   <= cfg_data[12:0];
                REG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg_data[12:0];
                REG_EXTRA_BYTES:  cfg_reg.extra_bytes  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Handshakes
    assign in_stall = q_full;
    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = out_valid && !out_stall;

    slrle_core #(
        .MAX_LINE (MAX_LINE)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .acc    (in_acc),
        .pixel  (pixel),
        .cfg    (cfg_reg),
        .push_n (push_n),
        .recs   (recs)
    );

    slrle_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (push_n),
        .recs      (recs),
        .pop       (out_acc),
        .not_empty (out_valid),
        .full      (q_full),
        .head      (head)
    );

    // Output fields from the queue head
    assign record_kind  = head.kind;
    assign byte_address = head.addr;
    assign first_byte   = head.b0;
    assign second_byte  = head.b1;
    assign line_number  = head.line;
    assign line_offset  = head.offs;
    assign total_bytes  = head.total;
    assign image_end    = head.img_end;
    assign last         = head.last;

endmodule

>>> src/slrle_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slrle_chk
// Port-level checks on the record channel of the scanline RLE encoder.
// ----------------------------------------------------------------------------
`include "scanline_rle_encoder_with_clip_defines.svh"

module slrle_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  record_kind,
    input logic        image_end,
    input logic        last,
    input logic [15:0] line_offset
);
    import slrle_pkg::*;

    // A stalled record stays offered
    `SLRLE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

    // A line start record always closes the records of its pixel
    `SLRLE_ASSERT_IMPLY(a_start_last, clk, rst_n, out_valid && record_kind == KIND_START, last)

    // A clip record is never the last record of its pixel; its line start record follows
    `SLRLE_ASSERT_IMPLY(a_clip_not_last, clk, rst_n, out_valid && record_kind == KIND_CLIP, !last)

    // End of image is flagged only on start records
    `SLRLE_ASSERT_IMPLY(a_end_on_start, clk, rst_n, out_valid && image_end, record_kind == KIND_START)

    // Only start records carry a line offset
    `SLRLE_ASSERT_IMPLY(a_offs_start, clk, rst_n, out_valid && line_offset != 16'd0, record_kind == KIND_START)

endmodule

bind scanline_rle_encoder_with_clip slrle_chk u_slrle_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .record_kind (record_kind),
    .image_end   (image_end),
    .last        (last),
    .line_offset (line_offset)
);
